// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define MI3_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mi3 assertion failed");

// An implication: when ante holds, cons must hold.
`define MI3_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mi3 implication failed");

`endif

// ----- rtl/mi3_pkg.sv -----
`timescale 1ns / 1ps
package mi3_pkg;

  // Entry format: signed fixed point, EW bits with FB fraction bits.
  localparam int unsigned EW = 32;
  localparam int unsigned FB = 16;

  // Cofactor and determinant widths (both exact).
  localparam int unsigned CW = 2 * EW + 1;
  localparam int unsigned DW = 3 * EW + 3;

  // Divider: quotient bits, dividend width and compare width.
  localparam int unsigned QW = EW;
  localparam int unsigned NA = 2 * EW + 2 * FB + 1;
  localparam int unsigned NW = ((NA > DW - 1) ? NA : DW - 1) + 1;
  localparam int unsigned XW = ((NW > DW + QW) ? NW : DW + QW) + 1;
  localparam int unsigned DivLat = QW + 1;

  typedef logic signed [EW-1:0] entry_t;
  typedef logic signed [CW-1:0] cof_t;
  typedef logic signed [DW-1:0] det_t;

  typedef struct packed {
    logic          ovf;
    logic [QW-1:0] quo;
  } quo_t;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StSingular = 2'd1,
    StSat      = 2'd2
  } status_e;

endpackage

// ----- rtl/matrix_3x3_inverse_top.sv -----
// Throughput: one matrix per cycle; busy is always low and the block never stalls.
// Depth is set mostly by the 32 quotient-bit stages of the nine lane dividers.
// Reset (rst_ni low, asynchronous) clears every valid bit; words in flight are dropped.
`timescale 1ns / 1ps
module matrix_3x3_inverse_top import mi3_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  entry_t        a_xx_i,
  input  entry_t        a_xy_i,
  input  entry_t        a_xz_i,
  input  entry_t        a_yx_i,
  input  entry_t        a_yy_i,
  input  entry_t        a_yz_i,
  input  entry_t        a_zx_i,
  input  entry_t        a_zy_i,
  input  entry_t        a_zz_i,
  output logic          done_o,
  output entry_t        inv_xx_o,
  output entry_t        inv_xy_o,
  output entry_t        inv_xz_o,
  output entry_t        inv_yx_o,
  output entry_t        inv_yy_o,
  output entry_t        inv_yz_o,
  output entry_t        inv_zx_o,
  output entry_t        inv_zy_o,
  output entry_t        inv_zz_o,
  output entry_t        determinant_o,
  output logic [1:0]    status_o
);

  // Saturation limits for the magnitude of a positive and a negative result.
  localparam logic [EW-1:0] LimPos = {1'b0, {(EW-1){1'b1}}};
  localparam logic [EW-1:0] LimNeg = {1'b1, {(EW-1){1'b0}}};

  // The pipeline never holds a word back, so a new matrix is taken every cycle.
  assign busy = 1'b0;

  // Input register: the accepted word and its valid bit.
  logic   in_v_q;
  entry_t a_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= '{a_xx_i, a_xy_i, a_xz_i, a_yx_i, a_yy_i, a_yz_i, a_zx_i, a_zy_i, a_zz_i};
  end

  // Two stages of 2x2 cofactors, then three stages of first-row expansion.
  logic   cof_v;
  entry_t cof_row [3];
  cof_t   cof_c [9];

  mi3_cof u_cof (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_v_q),
    .a_i    (a_q),
    .valid_o(cof_v),
    .row_o  (cof_row),
    .c_o    (cof_c)
  );

  logic det_v;
  cof_t det_c [9];
  det_t det;

  mi3_det u_det (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(cof_v),
    .row_i  (cof_row),
    .c_i    (cof_c),
    .valid_o(det_v),
    .c_o    (det_c),
    .det_o  (det)
  );

  // Prepare stage. Every inverse entry is round(C * 2^(2F) / D), rounded half
  // away from zero. It is done on magnitudes as floor((2|N| + |D|) / (2|D|)),
  // and the sign is put back at the end. The determinant output needs only a
  // shift: floor((2|D| + 2^(2F)) / 2^(2F+1)), then saturation.
  logic [DW-1:0] dmag;
  logic [DW:0]   detr;
  logic          det_sat_d;
  logic [EW-1:0] det_lim, det_val, det_out_d;
  logic [CW-1:0] cmag [9];
  logic [NW-1:0] num_d [9];
  logic [8:0]    neg_d;

  always_comb begin
    dmag      = det[DW-1] ? DW'(-det) : DW'(det);
    detr      = ({dmag, 1'b0} + ((DW+1)'(1) << (2 * FB))) >> (2 * FB + 1);
    det_lim   = det[DW-1] ? LimNeg : LimPos;
    det_sat_d = detr > (DW+1)'(det_lim);
    det_val   = det_sat_d ? det_lim : detr[EW-1:0];
    det_out_d = det[DW-1] ? (EW'(0) - det_val) : det_val;
    for (int i = 0; i < 9; i++) begin
      cmag[i]  = det_c[i][CW-1] ? CW'(-det_c[i]) : CW'(det_c[i]);
      num_d[i] = (NW'(cmag[i]) << (2 * FB + 1)) + NW'(dmag);
      neg_d[i] = det_c[i][CW-1] ^ det[DW-1];
    end
  end

  logic          pre_v_q;
  logic [NW-1:0] num_q [9];
  logic [DW-1:0] den_q;
  logic [8:0]    neg_q;
  logic          zero_q, det_sat_q;
  logic [EW-1:0] det_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_v_q <= 1'b0;
    end else begin
      pre_v_q <= det_v;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q     <= num_d;
    den_q     <= {dmag[DW-2:0], 1'b0};
    neg_q     <= neg_d;
    zero_q    <= (det == '0);
    det_sat_q <= det_sat_d;
    det_out_q <= det_out_d;
  end

  // Nine dividers run side by side, one per inverse entry.
  quo_t quo [9];

  for (genvar i = 0; i < 9; i++) begin : g_lane
    mi3_div u_div (
      .clk_i(clk_i),
      .num_i(num_q[i]),
      .den_i(den_q),
      .quo_o(quo[i])
    );
  end

  // The side information rides a delay line as long as the dividers.
  logic          dl_v_q    [DivLat];
  logic [8:0]    dl_neg_q  [DivLat];
  logic          dl_zero_q [DivLat];
  logic          dl_dsat_q [DivLat];
  logic [EW-1:0] dl_det_q  [DivLat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DivLat; s++) begin
        dl_v_q[s] <= 1'b0;
      end
    end else begin
      dl_v_q[0] <= pre_v_q;
      for (int s = 1; s < DivLat; s++) begin
        dl_v_q[s] <= dl_v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dl_neg_q[0]  <= neg_q;
    dl_zero_q[0] <= zero_q;
    dl_dsat_q[0] <= det_sat_q;
    dl_det_q[0]  <= det_out_q;
    for (int s = 1; s < DivLat; s++) begin
      dl_neg_q[s]  <= dl_neg_q[s-1];
      dl_zero_q[s] <= dl_zero_q[s-1];
      dl_dsat_q[s] <= dl_dsat_q[s-1];
      dl_det_q[s]  <= dl_det_q[s-1];
    end
  end

  // Output stage: clamp each quotient to the signed range and apply the sign.
  // A singular matrix overrides everything with zeros and its own status.
  logic          last_neg;
  logic [EW-1:0] lim [9];
  logic [EW-1:0] val [9];
  logic [8:0]    lane_sat;
  entry_t        inv_d [9];
  entry_t        det_d;
  status_e       status_d;

  always_comb begin
    last_neg = 1'b0;
    for (int i = 0; i < 9; i++) begin
      last_neg    = dl_neg_q[DivLat-1][i];
      lim[i]      = last_neg ? LimNeg : LimPos;
      lane_sat[i] = quo[i].ovf | (quo[i].quo > lim[i]);
      val[i]      = lane_sat[i] ? lim[i] : quo[i].quo;
      inv_d[i]    = dl_zero_q[DivLat-1] ? '0 :
                    (last_neg ? $signed(EW'(0) - val[i]) : $signed(val[i]));
    end
    det_d = dl_zero_q[DivLat-1] ? '0 : $signed(dl_det_q[DivLat-1]);
    priority if (dl_zero_q[DivLat-1]) begin
      status_d = StSingular;
    end else if ((|lane_sat) | dl_dsat_q[DivLat-1]) begin
      status_d = StSat;
    end else begin
      status_d = StOk;
    end
  end

  logic    done_q;
  entry_t  inv_q [9];
  entry_t  det_q;
  status_e status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dl_v_q[DivLat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    inv_q    <= inv_d;
    det_q    <= det_d;
    status_q <= status_d;
  end

  assign done_o        = done_q;
  assign inv_xx_o      = inv_q[0];
  assign inv_xy_o      = inv_q[1];
  assign inv_xz_o      = inv_q[2];
  assign inv_yx_o      = inv_q[3];
  assign inv_yy_o      = inv_q[4];
  assign inv_yz_o      = inv_q[5];
  assign inv_zx_o      = inv_q[6];
  assign inv_zy_o      = inv_q[7];
  assign inv_zz_o      = inv_q[8];
  assign determinant_o = det_q;
  assign status_o      = status_q;

endmodule

// ----- rtl/mi3_cof.sv -----
`timescale 1ns / 1ps
module mi3_cof import mi3_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  entry_t a_i [9],
  output logic   valid_o,
  output entry_t row_o [3],
  output cof_t   c_o [9]
);

  // Each cofactor is a[P]*a[Q] - a[R]*a[S], in adjugate row-major order.
  localparam int IdxP [9] = '{4, 7, 1, 5, 8, 2, 3, 6, 0};
  localparam int IdxQ [9] = '{8, 2, 5, 6, 0, 3, 7, 1, 4};
  localparam int IdxR [9] = '{5, 1, 2, 3, 6, 5, 6, 7, 1};
  localparam int IdxS [9] = '{7, 8, 4, 8, 2, 0, 4, 0, 3};

  logic                   v1_q, v2_q;
  logic signed [2*EW-1:0] p_q [9];
  logic signed [2*EW-1:0] s_q [9];
  entry_t                 row1_q [3];
  entry_t                 row2_q [3];
  cof_t                   c_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 9; i++) begin
      p_q[i] <= a_i[IdxP[i]] * a_i[IdxQ[i]];
      s_q[i] <= a_i[IdxR[i]] * a_i[IdxS[i]];
      c_q[i] <= CW'(p_q[i]) - CW'(s_q[i]);
    end
    for (int j = 0; j < 3; j++) begin
      row1_q[j] <= a_i[j];
      row2_q[j] <= row1_q[j];
    end
  end

  assign valid_o = v2_q;
  assign row_o   = row2_q;
  assign c_o     = c_q;

endmodule

// ----- rtl/mi3_det.sv -----
`timescale 1ns / 1ps
module mi3_det import mi3_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  entry_t row_i [3],
  input  cof_t   c_i [9],
  output logic   valid_o,
  output cof_t   c_o [9],
  output det_t   det_o
);

  // First-row expansion uses the adjugate's first column: c0, c3, c6.
  localparam int CIdx [3] = '{0, 3, 6};

  logic                 v1_q, v2_q, v3_q;
  logic signed [2*EW:0] lo_q [3];
  logic signed [2*EW:0] hi_q [3];
  det_t                 prod_q [3];
  det_t                 det_q;
  cof_t                 c1_q [9];
  cof_t                 c2_q [9];
  cof_t                 c3_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // The wide product is split into two partial products over cofactor halves of about entry size.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      lo_q[k]   <= row_i[k] * $signed({1'b0, c_i[CIdx[k]][EW-1:0]});
      hi_q[k]   <= row_i[k] * $signed(c_i[CIdx[k]][CW-1:EW]);
      prod_q[k] <= (DW'(hi_q[k]) <<< EW) + DW'(lo_q[k]);
    end
    det_q <= prod_q[0] + prod_q[1] + prod_q[2];
    c1_q  <= c_i;
    c2_q  <= c1_q;
    c3_q  <= c2_q;
  end

  assign valid_o = v3_q;
  assign c_o     = c3_q;
  assign det_o   = det_q;

endmodule

// ----- rtl/mi3_div.sv -----
`timescale 1ns / 1ps
module mi3_div import mi3_pkg::*; (
  input  logic          clk_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output quo_t          quo_o
);

  // Restoring division, one quotient bit per stage. The first stage flags a
  // quotient too large for QW bits; the output stage saturates the result then.
  logic [NW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW+1];
  logic          ovf_q [QW+1];

  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_i;
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    ovf_q[0] <= {{(XW-NW){1'b0}}, num_i} >= ({{(XW-DW){1'b0}}, den_i} << QW);
  end

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    localparam int unsigned K = QW - s;
    logic [XW-1:0] trial;
    logic          take;
    logic [QW-1:0] quo_d;

    always_comb begin
      trial    = {{(XW-DW){1'b0}}, den_q[s-1]} << K;
      take     = {{(XW-NW){1'b0}}, rem_q[s-1]} >= trial;
      quo_d    = quo_q[s-1];
      quo_d[K] = take;
    end

    always_ff @(posedge clk_i) begin
      quo_q[s] <= quo_d;
      ovf_q[s] <= ovf_q[s-1];
    end

    if (s < QW) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_q[s] <= take ? (rem_q[s-1] - trial[NW-1:0]) : rem_q[s-1];
        den_q[s] <= den_q[s-1];
      end
    end
  end

  assign quo_o = '{ovf: ovf_q[QW], quo: quo_q[QW]};

endmodule

// ----- rtl/mi3_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mi3_checker import mi3_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input entry_t     inv_xx_o,
  input entry_t     inv_xy_o,
  input entry_t     inv_xz_o,
  input entry_t     inv_yx_o,
  input entry_t     inv_yy_o,
  input entry_t     inv_yz_o,
  input entry_t     inv_zx_o,
  input entry_t     inv_zy_o,
  input entry_t     inv_zz_o,
  input entry_t     determinant_o,
  input logic       done_o,
  input logic [1:0] status_o
);

  // Every accepted word comes out a fixed number of cycles later.
  `MI3_ASSERT_IMPL(a_latency, clk_i, rst_ni, start && !busy, ##41 done_o)

  // The pipeline takes a new word in every cycle.
  `MI3_ASSERT(a_never_busy, clk_i, rst_ni, !busy)

  // A singular matrix gives a zero determinant and zeros on the inverse's diagonal.
  `MI3_ASSERT_IMPL(a_singular_zero, clk_i, rst_ni, done_o && status_o == StSingular,
    determinant_o == '0 && inv_xx_o == '0 && inv_yy_o == '0 && inv_zz_o == '0)

  // Every finished word carries one of the defined status codes.
  `MI3_ASSERT_IMPL(a_status_code, clk_i, rst_ni, done_o,
    status_o == StOk || status_o == StSingular || status_o == StSat)

endmodule

bind matrix_3x3_inverse_top mi3_checker u_mi3_checker (.*);
